/* rtl/laplacian_edge_filter_assert.svh */
// Assertion macros shared by the Laplacian edge filter RTL.
`ifndef LAPLACIAN_EDGE_FILTER_ASSERT_SVH
`define LAPLACIAN_EDGE_FILTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LEF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("laplacian_edge_filter: assertion failed");

// Next-cycle implication, checked out of reset.
`define LEF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("laplacian_edge_filter: assertion failed");

`endif

/* rtl/lef_pkg.sv */
// Types and constants of the Laplacian edge filter.
`default_nettype none
package lef_pkg;

  localparam int NUM_LANES = 3;
  localparam int SMP_W     = 8;
  // Widths cover kernels up to 15x15: multiplier up to 224.
  localparam int M_W       = 8;
  localparam int ACC_W     = 18;
  localparam int X_W       = 17;
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 16;

  localparam logic [1:0] SIDE_POS  = 2'd0;
  localparam logic [1:0] SIDE_NEG  = 2'd1;
  localparam logic [1:0] SIDE_BOTH = 2'd2;

  typedef enum logic [CFG_AW-1:0] {
    REG_RADIUS = 2'd0,
    REG_SIDE   = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SMP_W-1:0] in_blue;
    logic [SMP_W-1:0] in_green;
    logic [SMP_W-1:0] in_red;
    logic             drain;
  } pix_t;

  typedef struct packed {
    logic [SMP_W-1:0] out_blue;
    logic [SMP_W-1:0] out_green;
    logic [SMP_W-1:0] out_red;
    logic             frame_end;
  } res_t;

  typedef struct packed {
    logic       clear;
    logic       acc_en;
    logic       in_img;
    logic       center;
    logic       div_load;
    logic       div_step;
  } lane_ctl_t;

endpackage
`default_nettype wire

/* rtl/lef_if.sv */
// Stream and configuration interfaces of the Laplacian edge filter.
`default_nettype none
interface lef_pix_if;
  logic          valid;
  logic          ready;
  lef_pkg::pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lef_res_if;
  logic          valid;
  logic          ready;
  lef_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lef_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lef_pkg::CFG_AW-1:0]  addr;
  logic [lef_pkg::CFG_DW-1:0]  data;
  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

/* rtl/lef_lane.sv */
// One color channel: window accumulator, side selection and divide by n*n-1.
`default_nettype none
module lef_lane (
  input  logic                        clk,
  input  lef_pkg::lane_ctl_t          ctl,
  input  logic [lef_pkg::SMP_W-1:0]   sample,
  input  logic [lef_pkg::M_W-1:0]     mult,
  input  logic [1:0]                  side,
  output logic [lef_pkg::SMP_W-1:0]   result
);
  import lef_pkg::*;

  localparam int              SX_W   = 10;
  localparam int              PR_W   = 21;
  localparam int              R3_SH  = 11;
  localparam logic [PR_W-1:0] RECIP3 = PR_W'(683);

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] kept;
  logic [M_W+SMP_W-1:0]    prod;
  logic [X_W-1:0]          mag;
  logic [SX_W-1:0]         scaled;
  logic [PR_W-1:0]         third;
  logic [SX_W-1:0]         x_r;
  logic                    div3_r;
  logic [SMP_W-1:0]        q_r;

  always_comb begin
    prod = {{SMP_W{1'b0}}, mult} * {{M_W{1'b0}}, sample};
    if (!ctl.in_img) begin
      term = '0;
    end else if (ctl.center) begin
      term = $signed(ACC_W'(prod));
    end else begin
      term = -$signed(ACC_W'(sample));
    end
  end

  always_comb begin
    kept = acc_r;
    if ((side == SIDE_POS && acc_r < 0) || (side == SIDE_NEG && acc_r > 0)) begin
      kept = '0;
    end
    mag = (kept < 0) ? X_W'(-kept) : X_W'(kept);
    // The divisor is 8, 24 or 48: shift out the power of two, then divide by
    // three with a reciprocal multiply that is exact for values below 2048.
    scaled = (mult == M_W'(48)) ? SX_W'(mag >> 4) : SX_W'(mag >> 3);
    third  = PR_W'(x_r) * RECIP3;
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + term;
    end
    if (ctl.div_load) begin
      x_r    <= scaled;
      div3_r <= (mult != M_W'(8));
    end
    if (ctl.div_step) begin
      q_r <= div3_r ? third[R3_SH +: SMP_W] : SMP_W'(x_r);
    end
  end

  assign result = q_r;

endmodule
`default_nettype wire

/* rtl/lef_out_reg.sv */
// Merges the lane results into one result item and holds it for transfer.
`default_nettype none
module lef_out_reg (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            load,
  input  logic [lef_pkg::NUM_LANES-1:0][lef_pkg::SMP_W-1:0] lanes,
  input  logic                                            frame_end,
  output logic                                            full,
  lef_res_if.source                                       res
);
  import lef_pkg::*;

  logic valid_r;
  res_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (res.ready) begin
      valid_r <= 1'b0;
    end
    if (load) begin
      data_r.out_blue  <= lanes[0];
      data_r.out_green <= lanes[1];
      data_r.out_red   <= lanes[2];
      data_r.frame_end <= frame_end;
    end
  end

  assign full      = valid_r && !res.ready;
  assign res.valid = valid_r;
  assign res.data  = data_r;

endmodule
`default_nettype wire

/* rtl/laplacian_edge_filter.sv */
// Top level of the three-channel Laplacian edge filter.
//
//  channel | direction | payload                                   | handshake
//  in_pix  | in        | in_blue, in_green, in_red, drain           | valid/ready
//  out_res | out       | out_blue, out_green, out_red, frame_end    | valid/ready
//  cfg_wr  | in        | addr (register index), data                | valid/ready
//
// An item with no result passes only the idle and check states; one with a
// result also reads its n*n window (n = 2r+1) from the single-port row store,
// one tap per cycle, then the flush, load, divide and output states drain the
// read, scale the sums, divide by three and load the output register.
// Reset is synchronous and active low; the row store is not cleared.
// A result waiting in the output register does not block the next input;
// the block only stalls when a new result is ready and the old one is unsent.
`default_nettype none
module laplacian_edge_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 7
) (
  input  logic      clk,
  input  logic      rst_n,
  lef_pix_if.sink   in_pix,
  lef_res_if.source out_res,
  lef_cfg_if.sink   cfg_wr
);
  import lef_pkg::*;

  localparam int CB    = $clog2(MAX_WIDTH);
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int RMAX  = (MAX_KERNEL - 1) / 2;
  localparam int RING  = 2 ** $clog2(MAX_KERNEL + 1);
  localparam int RB    = $clog2(RING);
  localparam int AB    = RB + CB;
  localparam int DEPTH = RING * (2 ** CB);
  localparam int CNT_W = 16 + CB;
  localparam int LAG_W = WB + 3;
  localparam int CC_W  = CB + 2;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_WIN   = 7'b0000100,
    ST_FLUSH = 7'b0001000,
    ST_LOAD  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]  rad_r, side_r;
  logic [10:0] wid_r;
  logic [15:0] hgt_r;

  logic [15:0]      in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [CB-1:0]    in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [CNT_W-1:0] recv_cnt_r, recv_cnt_nxt, out_cnt_r, out_cnt_nxt;
  logic [2:0]       dr_r, dr_nxt, dc_r, dc_nxt;

  logic [1:0]       r_eff, side_eff;
  logic [2:0]       n_eff;
  logic [5:0]       m6;
  logic [M_W-1:0]   mult;
  logic [WB-1:0]    w_eff;
  logic [15:0]      h_eff;
  logic [LAG_W-1:0] lag;
  logic             in_done, due, take, accept, cfg_we;
  logic [CB:0]      col_inc, ocol_inc;
  logic             col_wrap, ocol_wrap, frame_end, out_full, out_load;

  logic signed [17:0]   rr;
  logic signed [CC_W-1:0] cc;
  logic             in_img, center;

  logic [23:0]      mem [DEPTH];
  logic [23:0]      mem_q_r;
  logic [AB-1:0]    rd_addr, wr_addr;
  logic             mem_we;
  logic             rd_v_r, rd_in_r, rd_ctr_r;

  lane_ctl_t                          lane_ctl;
  logic [NUM_LANES-1:0][SMP_W-1:0]    lane_res;

  // Effective register values.
  always_comb begin
    r_eff = rad_r;
    if (rad_r == 2'd0) begin
      r_eff = 2'd1;
    end
    if (32'(r_eff) > RMAX) begin
      r_eff = 2'(RMAX);
    end
    n_eff = {r_eff, 1'b0} + 3'd1;
    m6    = 6'(n_eff) * 6'(n_eff) - 6'd1;
    mult  = M_W'(m6);
    if (wid_r == 11'd0) begin
      w_eff = WB'(1);
    end else if (32'(wid_r) > MAX_WIDTH) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = WB'(wid_r);
    end
    h_eff    = (hgt_r == 16'd0) ? 16'd1 : hgt_r;
    side_eff = (side_r == 2'd3) ? SIDE_BOTH : side_r;
    lag      = LAG_W'(r_eff) * LAG_W'(w_eff) + LAG_W'(r_eff);
  end

  assign in_done = in_row_r >= h_eff;
  assign due     = in_done ||
                   ((CNT_W+1)'(recv_cnt_r) > (CNT_W+1)'(out_cnt_r) + (CNT_W+1)'(lag));

  assign in_pix.ready = (state_r == ST_IDLE);
  assign accept       = in_pix.valid && in_pix.ready;
  assign take         = accept && !in_pix.data.drain && !in_done;
  assign cfg_wr.ready = 1'b1;
  assign cfg_we       = cfg_wr.valid && cfg_wr.ready;

  assign col_inc   = (CB+1)'(in_col_r) + (CB+1)'(1);
  assign col_wrap  = col_inc >= (CB+1)'(w_eff);
  assign ocol_inc  = (CB+1)'(out_col_r) + (CB+1)'(1);
  assign ocol_wrap = ocol_inc >= (CB+1)'(w_eff);
  assign frame_end = ocol_wrap && ({1'b0, out_row_r} + 17'd1 >= {1'b0, h_eff});
  assign out_load  = (state_r == ST_OUT) && !out_full;

  // Window tap position relative to the output pixel.
  always_comb begin
    rr = $signed({2'b00, out_row_r}) + $signed(18'(dr_r)) - $signed(18'(r_eff));
    cc = $signed(CC_W'(out_col_r)) + $signed(CC_W'(dc_r)) - $signed(CC_W'(r_eff));
    in_img = (rr >= 0) && (rr < $signed({2'b00, h_eff})) &&
             (cc >= 0) && (cc < $signed(CC_W'(w_eff)));
    center  = (dr_r == {1'b0, r_eff}) && (dc_r == {1'b0, r_eff});
    rd_addr = {rr[RB-1:0], cc[CB-1:0]};
    wr_addr = {in_row_r[RB-1:0], in_col_r};
    mem_we  = take;
  end

  always_comb begin
    state_nxt    = state_r;
    in_row_nxt   = in_row_r;
    in_col_nxt   = in_col_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    recv_cnt_nxt = recv_cnt_r;
    out_cnt_nxt  = out_cnt_r;
    dr_nxt       = dr_r;
    dc_nxt       = dc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CHECK;
          if (take) begin
            recv_cnt_nxt = recv_cnt_r + CNT_W'(1);
            if (col_wrap) begin
              in_col_nxt = '0;
              in_row_nxt = in_row_r + 16'd1;
            end else begin
              in_col_nxt = CB'(col_inc);
            end
          end
        end
      end
      ST_CHECK: begin
        state_nxt = due ? ST_WIN : ST_IDLE;
        dr_nxt    = '0;
        dc_nxt    = '0;
      end
      ST_WIN: begin
        if (dc_r == n_eff - 3'd1) begin
          dc_nxt = '0;
          if (dr_r == n_eff - 3'd1) begin
            state_nxt = ST_FLUSH;
          end else begin
            dr_nxt = dr_r + 3'd1;
          end
        end else begin
          dc_nxt = dc_r + 3'd1;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_full) begin
          state_nxt   = ST_IDLE;
          out_cnt_nxt = out_cnt_r + CNT_W'(1);
          if (ocol_wrap) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + 16'd1;
          end else begin
            out_col_nxt = CB'(ocol_inc);
          end
          // The frame is complete: all positions return to the start.
          if (frame_end) begin
            in_row_nxt   = '0;
            in_col_nxt   = '0;
            out_row_nxt  = '0;
            out_col_nxt  = '0;
            recv_cnt_nxt = '0;
            out_cnt_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // A register write restarts the frame.
    if (cfg_we) begin
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      out_row_nxt  = '0;
      out_col_nxt  = '0;
      recv_cnt_nxt = '0;
      out_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rad_r      <= 2'd1;
      side_r     <= SIDE_BOTH;
      wid_r      <= 11'd1024;
      hgt_r      <= 16'd1024;
      in_row_r   <= '0;
      in_col_r   <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      recv_cnt_r <= '0;
      out_cnt_r  <= '0;
      dr_r       <= '0;
      dc_r       <= '0;
      rd_v_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      recv_cnt_r <= recv_cnt_nxt;
      out_cnt_r  <= out_cnt_nxt;
      dr_r       <= dr_nxt;
      dc_r       <= dc_nxt;
      rd_v_r     <= (state_r == ST_WIN);
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_wr.addr))
          REG_RADIUS: rad_r  <= cfg_wr.data[1:0];
          REG_SIDE:   side_r <= cfg_wr.data[1:0];
          REG_WIDTH:  wid_r  <= cfg_wr.data[10:0];
          REG_HEIGHT: hgt_r  <= cfg_wr.data;
          default: begin
          end
        endcase
      end
    end
  end

  // Row store: written by the input side, read one window tap per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {in_pix.data.in_red, in_pix.data.in_green, in_pix.data.in_blue};
    end
    mem_q_r  <= mem[rd_addr];
    rd_in_r  <= in_img;
    rd_ctr_r <= center;
  end

  always_comb begin
    lane_ctl.clear    = (state_r == ST_CHECK);
    lane_ctl.acc_en   = rd_v_r;
    lane_ctl.in_img   = rd_in_r;
    lane_ctl.center   = rd_ctr_r;
    lane_ctl.div_load = (state_r == ST_LOAD);
    lane_ctl.div_step = (state_r == ST_DIV);
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lef_lane u_lane (
      .clk    (clk),
      .ctl    (lane_ctl),
      .sample (mem_q_r[SMP_W*g +: SMP_W]),
      .mult   (mult),
      .side   (side_eff),
      .result (lane_res[g])
    );
  end

  lef_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .lanes     (lane_res),
    .frame_end (frame_end),
    .full      (out_full),
    .res       (out_res)
  );

`include "laplacian_edge_filter_assert.svh"

  `LEF_ASSERT_IMP(a_rd_in_window, clk, rst_n, rd_v_r, (state_r == ST_WIN || state_r == ST_FLUSH))
  `LEF_ASSERT_IMP(a_out_behind_in, clk, rst_n, 1'b1, (out_cnt_r <= recv_cnt_r))
  `LEF_ASSERT_NXT(a_frame_restart, clk, rst_n, (out_load && frame_end), (recv_cnt_r == '0 && out_cnt_r == '0 && in_row_r == '0))

endmodule
`default_nettype wire
